// ===== src/gkc_pkg.sv =====
// shared types and constants for the graph colouring block
package gkc_pkg;

   localparam int ROW_W      = 32;  // adjacency row width on the input channel
   localparam int VCFG_W     = 6;   // vertex_count register width
   localparam int KCFG_W     = 5;   // colour_count register width
   localparam int COL_W      = 5;   // stored and reported colour width
   localparam int VTX_W      = 5;   // reported vertex width
   localparam int CAND_W     = 6;   // candidate colour, may run one past k
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_ADDR_W-1:0] CSR_VERTEX_COUNT = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COLOUR_COUNT = 1'd1;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic load_row;
      logic fetch;
      logic next_cand;
      logic place;
      logic unplace;
      logic v_inc;
      logic v_dec;
      logic v_zero;
      logic emit_ok;
      logic emit_fail;
      logic clear;
   } gkc_cmd_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic row_done;
      logic cand_over;
      logic fits;
      logic v_first;
      logic v_last;
      logic out_free;
   } gkc_status_type;

endpackage

// ===== src/gkc_ctrl.sv =====
// sequencer for row loading, backtracking search and result emission
module gkc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gkc_pkg::gkc_status_type status,
   output gkc_pkg::gkc_cmd_type    cmd
);
   import gkc_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH,
      ST_TRY,
      ST_EMIT,
      ST_FAIL
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_LOAD);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load_row = 1'b1;
               if (status.row_done) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_TRY;
         end
         ST_TRY: begin
            if (status.cand_over) begin
               // no colour left for this vertex: back up
               cmd.unplace = 1'b1;
               if (status.v_first) begin
                  state_in = ST_FAIL;
               end else begin
                  cmd.v_dec = 1'b1;
                  state_in  = ST_FETCH;
               end
            end else if (status.fits) begin
               cmd.place = 1'b1;
               if (status.v_last) begin
                  cmd.v_zero = 1'b1;
                  state_in   = ST_EMIT;
               end else begin
                  cmd.v_inc = 1'b1;
                  state_in  = ST_FETCH;
               end
            end else begin
               cmd.next_cand = 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_ok = 1'b1;
               cmd.v_inc   = 1'b1;
               if (status.v_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_LOAD;
               end
            end
         end
         ST_FAIL: begin
            if (status.out_free) begin
               cmd.emit_fail = 1'b1;
               cmd.clear     = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

// ===== src/gkc_dp.sv =====
// datapath: config registers, adjacency memory, colour store, search and output registers
module gkc_dp #(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_COLOURS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [gkc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [gkc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [gkc_pkg::ROW_W-1:0]         req_row_bits,
   input  gkc_pkg::gkc_cmd_type              cmd,
   output gkc_pkg::gkc_status_type           status,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [gkc_pkg::VTX_W-1:0]         rsp_vertex,
   output logic [gkc_pkg::COL_W-1:0]         rsp_colour,
   output logic                              rsp_last
);
   import gkc_pkg::*;

   localparam int IDX_W     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
   localparam int CMP_W     = CNT_W + 1;
   localparam int NEXT_W    = VCFG_W + 1;
   localparam int ROW_EXT_W = (ROW_W > MAX_VERTICES) ? ROW_W : MAX_VERTICES;
   localparam int V_EXT_W   = (IDX_W > VTX_W) ? IDX_W : VTX_W;

   // configuration
   logic [VCFG_W-1:0] vcount_ff;
   logic [KCFG_W-1:0] kcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCFG_W'(32);
         kcount_ff <= KCFG_W'(3);
      end else if (csr_write) begin
         case (csr_addr)
            CSR_VERTEX_COUNT: vcount_ff <= csr_wdata[VCFG_W-1:0];
            CSR_COLOUR_COUNT: kcount_ff <= csr_wdata[KCFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // effective n and k after saturation
   logic [NEXT_W-1:0] vcount_ext;
   logic [CMP_W-1:0]  n_eff;
   logic [KCFG_W-1:0] k_eff;

   always_comb begin
      vcount_ext = NEXT_W'(vcount_ff);
      if (vcount_ff == '0) begin
         n_eff = CMP_W'(1);
      end else if (vcount_ext > NEXT_W'(MAX_VERTICES)) begin
         n_eff = CMP_W'(MAX_VERTICES);
      end else begin
         n_eff = CMP_W'(vcount_ext);
      end
      if (kcount_ff > KCFG_W'(MAX_COLOURS)) begin
         k_eff = KCFG_W'(MAX_COLOURS);
      end else begin
         k_eff = kcount_ff;
      end
   end

   // row loading
   logic [CNT_W-1:0]        rows_ff;
   logic [ROW_EXT_W-1:0]    row_ext;
   logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];

   assign row_ext = ROW_EXT_W'(req_row_bits);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
      end else if (cmd.clear) begin
         rows_ff <= '0;
      end else if (cmd.load_row) begin
         rows_ff <= rows_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_row) begin
         adj_mem[rows_ff[IDX_W-1:0]] <= row_ext[MAX_VERTICES-1:0];
      end
   end

   // search state
   logic [IDX_W-1:0]        v_ff;
   logic [CAND_W-1:0]       cand_ff;
   logic [MAX_VERTICES-1:0] row_ff;
   logic [COL_W-1:0]        cs_ff [MAX_VERTICES];
   logic [COL_W-1:0]        cs_cur;

   assign cs_cur = cs_ff[v_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (cmd.clear || cmd.v_zero) begin
         v_ff <= '0;
      end else if (cmd.v_inc) begin
         v_ff <= v_ff + IDX_W'(1);
      end else if (cmd.v_dec) begin
         v_ff <= v_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         row_ff  <= adj_mem[v_ff];
         cand_ff <= CAND_W'(cs_cur) + CAND_W'(1);
      end else if (cmd.next_cand) begin
         cand_ff <= cand_ff + CAND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < MAX_VERTICES; i++) begin
            cs_ff[i] <= '0;
         end
      end else if (cmd.place) begin
         cs_ff[v_ff] <= cand_ff[COL_W-1:0];
      end else if (cmd.unplace) begin
         cs_ff[v_ff] <= '0;
      end
   end

   // a neighbour below n, other than v itself, holding the candidate rejects it
   logic conflict;

   always_comb begin
      conflict = 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         if (row_ff[i] && (CMP_W'(i) < n_eff) && (IDX_W'(i) != v_ff) &&
             (CAND_W'(cs_ff[i]) == cand_ff)) begin
            conflict = 1'b1;
         end
      end
   end

   logic              out_free;
   logic [CMP_W-1:0]  v_next;
   logic [V_EXT_W-1:0] v_ext;

   assign v_next = CMP_W'(v_ff) + CMP_W'(1);
   assign v_ext  = V_EXT_W'(v_ff);

   always_comb begin
      status.row_done  = (CMP_W'(rows_ff) + CMP_W'(1)) >= n_eff;
      status.cand_over = cand_ff > CAND_W'(k_eff);
      status.fits      = !conflict;
      status.v_first   = (v_ff == '0);
      status.v_last    = v_next >= n_eff;
      status.out_free  = out_free;
   end

   // output register
   logic               out_valid_ff;
   logic               out_found_ff;
   logic [VTX_W-1:0]   out_vertex_ff;
   logic [COL_W-1:0]   out_colour_ff;
   logic               out_last_ff;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_ok || cmd.emit_fail) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_ok) begin
         out_found_ff  <= 1'b1;
         out_vertex_ff <= v_ext[VTX_W-1:0];
         out_colour_ff <= cs_cur;
         out_last_ff   <= status.v_last;
      end else if (cmd.emit_fail) begin
         out_found_ff  <= 1'b0;
         out_vertex_ff <= '0;
         out_colour_ff <= '0;
         out_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_found  = out_found_ff;
   assign rsp_vertex = out_vertex_ff;
   assign rsp_colour = out_colour_ff;
   assign rsp_last   = out_last_ff;

endmodule

// ===== src/graph_k_colouring_backtrack.sv =====
// Graph k-colouring by depth-first backtracking search.
// Input channel (req_): one adjacency row per transfer; bit j means an edge to
// vertex j. Rows load at one per cycle. The transfer of row n-1 starts the
// search, and req_stall stays high until the last result has gone into the
// output register.
// Search time: each vertex visit reads its row from the adjacency memory, then
// tries candidate colours in turn, and backs up to the previous vertex when no
// colour fits; backtracking repeats visits, so the total is data dependent and
// can grow exponentially in n.
// Result channel (rsp_): on success one transfer per vertex, in order, at up to
// one per cycle, rsp_last on the final one; on failure a single transfer with
// rsp_found low and rsp_last high. The output register holds a result while
// rsp_stall is high, and the search waits for it.
// Configuration (csr_): vertex_count and colour_count, written while idle.
// Reset: synchronous; returns to loading row 0, clears colours, sets
// vertex_count to 32 and colour_count to 3.
module graph_k_colouring_backtrack #(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_COLOURS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [gkc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [gkc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gkc_pkg::ROW_W-1:0]      req_row_bits,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_found,
   output logic [gkc_pkg::VTX_W-1:0]      rsp_vertex,
   output logic [gkc_pkg::COL_W-1:0]      rsp_colour,
   output logic                           rsp_last
);
   import gkc_pkg::*;

   gkc_cmd_type    cmd;
   gkc_status_type status;

   gkc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gkc_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_COLOURS  (MAX_COLOURS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .req_row_bits (req_row_bits),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_found    (rsp_found),
      .rsp_vertex   (rsp_vertex),
      .rsp_colour   (rsp_colour),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== src/gkc_checker.sv =====
// port-level checks for the graph colouring block, bound to the top level
module gkc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_found,
   input logic [gkc_pkg::VTX_W-1:0]      rsp_vertex,
   input logic [gkc_pkg::COL_W-1:0]      rsp_colour,
   input logic                           rsp_last
);
   import gkc_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) && $stable(rsp_vertex) &&
         $stable(rsp_colour) && $stable(rsp_last))
      else $error("stalled result changed");

   // failure result is a single closing transfer with zero fields
   a_fail_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_vertex == '0 && rsp_colour == '0)
      else $error("malformed failure result");

   // a reported colour is never the unassigned value
   a_colour_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_colour != '0)
      else $error("found result without a colour");

   // after reset the block is ready to load and has nothing pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind graph_k_colouring_backtrack gkc_checker u_gkc_checker (.*);
